[design/dwe_pkg.sv]
// ----------------------------------------------------------------------------
// Dual wheel encoder step drive package
// Shared widths, codes, reset values and word types of the step drive.
// ----------------------------------------------------------------------------
package dwe_pkg;

    localparam int DUTY_W         = 8;
    localparam int HOLES_W        = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int COUNT_BITS_DEF = 8;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LEFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RIGHT = 2'd3;

    localparam logic [DUTY_W-1:0] FAST_LEFT_RST  = 8'd60;
    localparam logic [DUTY_W-1:0] FAST_RIGHT_RST = 8'd60;
    localparam logic [DUTY_W-1:0] SLOW_LEFT_RST  = 8'd39;
    localparam logic [DUTY_W-1:0] SLOW_RIGHT_RST = 8'd45;

    typedef struct packed {
        logic [DUTY_W-1:0] fast_left;
        logic [DUTY_W-1:0] fast_right;
        logic [DUTY_W-1:0] slow_left;
        logic [DUTY_W-1:0] slow_right;
    } t_cfg;

    typedef struct packed {
        logic               cmd;
        logic [HOLES_W-1:0] target_holes;
        logic               left_dir_in;
        logic               right_dir_in;
        logic               enc_left;
        logic               enc_right;
    } t_in_word;

    typedef struct packed {
        logic               left_forward;
        logic [DUTY_W-1:0]  left_duty;
        logic               right_forward;
        logic [DUTY_W-1:0]  right_duty;
        logic               moving;
        logic               move_done;
        logic [HOLES_W-1:0] left_holes;
        logic [HOLES_W-1:0] right_holes;
    } t_out_word;

endpackage

[design/dwe_in_if.sv]
// ----------------------------------------------------------------------------
// Step drive input channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface dwe_in_if;

    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [dwe_pkg::HOLES_W-1:0]  target_holes;
    logic                         left_dir_in;
    logic                         right_dir_in;
    logic                         enc_left;
    logic                         enc_right;

    modport source (
        output valid, cmd, target_holes, left_dir_in, right_dir_in, enc_left, enc_right,
        input  ready
    );

    modport sink (
        input  valid, cmd, target_holes, left_dir_in, right_dir_in, enc_left, enc_right,
        output ready
    );

endinterface

[design/dwe_out_if.sv]
// ----------------------------------------------------------------------------
// Step drive output channel
// Valid/ready channel that carries one drive result word.
// ----------------------------------------------------------------------------
interface dwe_out_if;

    logic                         valid;
    logic                         ready;
    logic                         left_forward;
    logic [dwe_pkg::DUTY_W-1:0]   left_duty;
    logic                         right_forward;
    logic [dwe_pkg::DUTY_W-1:0]   right_duty;
    logic                         moving;
    logic                         move_done;
    logic [dwe_pkg::HOLES_W-1:0]  left_holes;
    logic [dwe_pkg::HOLES_W-1:0]  right_holes;

    modport source (
        output valid, left_forward, left_duty, right_forward, right_duty,
               moving, move_done, left_holes, right_holes,
        input  ready
    );

    modport sink (
        input  valid, left_forward, left_duty, right_forward, right_duty,
               moving, move_done, left_holes, right_holes,
        output ready
    );

endinterface

[design/dwe_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Step drive configuration registers
// Holds the fast and slow duty of each wheel, written through a plain port.
// ----------------------------------------------------------------------------
module dwe_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dwe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dwe_pkg::DUTY_W-1:0]      i_cfg_data,
    output dwe_pkg::t_cfg                   o_cfg
);

    dwe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_left  <= dwe_pkg::FAST_LEFT_RST;
            r_cfg.fast_right <= dwe_pkg::FAST_RIGHT_RST;
            r_cfg.slow_left  <= dwe_pkg::SLOW_LEFT_RST;
            r_cfg.slow_right <= dwe_pkg::SLOW_RIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dwe_pkg::CFG_FAST_LEFT:  r_cfg.fast_left  <= i_cfg_data;
                dwe_pkg::CFG_FAST_RIGHT: r_cfg.fast_right <= i_cfg_data;
                dwe_pkg::CFG_SLOW_LEFT:  r_cfg.slow_left  <= i_cfg_data;
                dwe_pkg::CFG_SLOW_RIGHT: r_cfg.slow_right <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/dwe_step.sv]
// ----------------------------------------------------------------------------
// Step drive evaluation
// Computes the drive word and the next move state for one command word.
// ----------------------------------------------------------------------------
module dwe_step #(
    parameter int COUNT_BITS = dwe_pkg::COUNT_BITS_DEF
) (
    input  dwe_pkg::t_in_word        i_word,
    input  dwe_pkg::t_cfg            i_cfg,
    input  logic [COUNT_BITS-1:0]    i_goal,
    input  logic [COUNT_BITS-1:0]    i_cnt_l,
    input  logic [COUNT_BITS-1:0]    i_cnt_r,
    input  logic                     i_seen_l,
    input  logic                     i_seen_r,
    input  logic                     i_last_l,
    input  logic                     i_last_r,
    input  logic                     i_dir_l,
    input  logic                     i_dir_r,
    input  logic                     i_active,
    output logic [COUNT_BITS-1:0]    o_goal,
    output logic [COUNT_BITS-1:0]    o_cnt_l,
    output logic [COUNT_BITS-1:0]    o_cnt_r,
    output logic                     o_seen_l,
    output logic                     o_seen_r,
    output logic                     o_last_l,
    output logic                     o_last_r,
    output logic                     o_dir_l,
    output logic                     o_dir_r,
    output logic                     o_active,
    output dwe_pkg::t_out_word       o_res
);

    localparam int WIDE_W = COUNT_BITS + dwe_pkg::HOLES_W;

    logic                        is_start;
    logic                        load;
    logic                        sample;
    logic [WIDE_W-1:0]           target_wide;
    logic [WIDE_W-1:0]           max_wide;
    logic [COUNT_BITS-1:0]       goal_sat;
    logic [COUNT_BITS-1:0]       goal;
    logic [COUNT_BITS-1:0]       cnt_l;
    logic [COUNT_BITS-1:0]       cnt_r;
    logic [COUNT_BITS-1:0]       cnt_l_nx;
    logic [COUNT_BITS-1:0]       cnt_r_nx;
    logic                        seen_l;
    logic                        seen_r;
    logic                        dir_l;
    logic                        dir_r;
    logic                        drv;
    logic                        below_l;
    logic                        below_r;
    logic                        inc_l;
    logic                        inc_r;
    logic                        reached;
    logic [dwe_pkg::DUTY_W-1:0]  duty_l;
    logic [dwe_pkg::DUTY_W-1:0]  duty_r;

    always_comb begin
        is_start    = (i_word.cmd == dwe_pkg::CMD_START);
        load        = is_start && !i_active;
        sample      = !is_start && i_active;

        target_wide = WIDE_W'(i_word.target_holes);
        max_wide    = WIDE_W'({COUNT_BITS{1'b1}});
        goal_sat    = (target_wide > max_wide) ? COUNT_BITS'(max_wide)
                                               : COUNT_BITS'(target_wide);

        goal   = load ? goal_sat : i_goal;
        cnt_l  = load ? '0 : i_cnt_l;
        cnt_r  = load ? '0 : i_cnt_r;
        seen_l = load ? 1'b0 : i_seen_l;
        seen_r = load ? 1'b0 : i_seen_r;
        dir_l  = load ? i_word.left_dir_in : i_dir_l;
        dir_r  = load ? i_word.right_dir_in : i_dir_r;
        drv    = load ? (goal_sat != '0) : i_active;

        below_l = cnt_l < goal;
        below_r = cnt_r < goal;
        inc_l   = below_l && sample && i_word.enc_left && !i_last_l;
        inc_r   = below_r && sample && i_word.enc_right && !i_last_r;
        cnt_l_nx = cnt_l + COUNT_BITS'(inc_l);
        cnt_r_nx = cnt_r + COUNT_BITS'(inc_r);

        duty_l = below_l ? (seen_l ? i_cfg.slow_left : i_cfg.fast_left) : '0;
        duty_r = below_r ? (seen_r ? i_cfg.slow_right : i_cfg.fast_right) : '0;
        if (cnt_r_nx < cnt_l_nx) begin
            duty_r = i_cfg.fast_right;
        end else if (cnt_r_nx > cnt_l_nx) begin
            duty_l = i_cfg.fast_left;
        end

        reached = (cnt_l_nx >= goal) && (cnt_r_nx >= goal);

        o_goal   = goal;
        o_cnt_l  = cnt_l_nx;
        o_cnt_r  = cnt_r_nx;
        o_seen_l = seen_l || inc_l;
        o_seen_r = seen_r || inc_r;
        o_last_l = sample ? i_word.enc_left : i_last_l;
        o_last_r = sample ? i_word.enc_right : i_last_r;
        o_dir_l  = dir_l;
        o_dir_r  = dir_r;
        o_active = sample ? !reached : drv;

        o_res.left_forward  = drv ? dir_l : 1'b1;
        o_res.left_duty     = drv ? duty_l : '0;
        o_res.right_forward = drv ? dir_r : 1'b1;
        o_res.right_duty    = drv ? duty_r : '0;
        o_res.moving        = o_active;
        o_res.move_done     = (load && (goal_sat == '0)) || (sample && reached);
        o_res.left_holes    = dwe_pkg::HOLES_W'(cnt_l_nx);
        o_res.right_holes   = dwe_pkg::HOLES_W'(cnt_r_nx);
    end

endmodule

[design/dual_wheel_encoder_step_drive.sv]
// ----------------------------------------------------------------------------
// Dual wheel encoder step drive
// Counts encoder holes on two wheels and sets their duty and direction.
// ----------------------------------------------------------------------------
// Each accepted word is held in an input register, evaluated, and its result is
// registered in the output register: one word per cycle while the output is taken.
// The input register lets a new word enter while a result waits to be taken, if it is empty.
// Reset clears the move state, the valid flags and loads the default duties.
module dual_wheel_encoder_step_drive #(
    parameter int COUNT_BITS = dwe_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dwe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dwe_pkg::DUTY_W-1:0]      i_cfg_data,
    dwe_in_if.sink                          i_in,
    dwe_out_if.source                       o_out
);

    dwe_pkg::t_cfg          cfg;
    dwe_pkg::t_in_word      in_word;
    dwe_pkg::t_in_word      r_in_word;
    dwe_pkg::t_out_word     r_out_word;
    dwe_pkg::t_out_word     n_out_word;
    logic                   r_in_valid;
    logic                   r_out_valid;
    logic                   advance;
    logic                   fire;
    logic                   in_ready;

    logic [COUNT_BITS-1:0]  r_goal;
    logic [COUNT_BITS-1:0]  r_cnt_l;
    logic [COUNT_BITS-1:0]  r_cnt_r;
    logic                   r_seen_l;
    logic                   r_seen_r;
    logic                   r_last_l;
    logic                   r_last_r;
    logic                   r_dir_l;
    logic                   r_dir_r;
    logic                   r_active;
    logic [COUNT_BITS-1:0]  n_goal;
    logic [COUNT_BITS-1:0]  n_cnt_l;
    logic [COUNT_BITS-1:0]  n_cnt_r;
    logic                   n_seen_l;
    logic                   n_seen_r;
    logic                   n_last_l;
    logic                   n_last_r;
    logic                   n_dir_l;
    logic                   n_dir_r;
    logic                   n_active;

    dwe_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign in_word.cmd          = i_in.cmd;
    assign in_word.target_holes = i_in.target_holes;
    assign in_word.left_dir_in  = i_in.left_dir_in;
    assign in_word.right_dir_in = i_in.right_dir_in;
    assign in_word.enc_left     = i_in.enc_left;
    assign in_word.enc_right    = i_in.enc_right;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign in_ready   = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    dwe_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .i_goal   (r_goal),
        .i_cnt_l  (r_cnt_l),
        .i_cnt_r  (r_cnt_r),
        .i_seen_l (r_seen_l),
        .i_seen_r (r_seen_r),
        .i_last_l (r_last_l),
        .i_last_r (r_last_r),
        .i_dir_l  (r_dir_l),
        .i_dir_r  (r_dir_r),
        .i_active (r_active),
        .o_goal   (n_goal),
        .o_cnt_l  (n_cnt_l),
        .o_cnt_r  (n_cnt_r),
        .o_seen_l (n_seen_l),
        .o_seen_r (n_seen_r),
        .o_last_l (n_last_l),
        .o_last_r (n_last_r),
        .o_dir_l  (n_dir_l),
        .o_dir_r  (n_dir_r),
        .o_active (n_active),
        .o_res    (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_word <= in_word;
        end
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal   <= '0;
            r_cnt_l  <= '0;
            r_cnt_r  <= '0;
            r_seen_l <= 1'b0;
            r_seen_r <= 1'b0;
            r_last_l <= 1'b0;
            r_last_r <= 1'b0;
            r_dir_l  <= 1'b1;
            r_dir_r  <= 1'b1;
            r_active <= 1'b0;
        end else if (fire) begin
            r_goal   <= n_goal;
            r_cnt_l  <= n_cnt_l;
            r_cnt_r  <= n_cnt_r;
            r_seen_l <= n_seen_l;
            r_seen_r <= n_seen_r;
            r_last_l <= n_last_l;
            r_last_r <= n_last_r;
            r_dir_l  <= n_dir_l;
            r_dir_r  <= n_dir_r;
            r_active <= n_active;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_forward  = r_out_word.left_forward;
    assign o_out.left_duty     = r_out_word.left_duty;
    assign o_out.right_forward = r_out_word.right_forward;
    assign o_out.right_duty    = r_out_word.right_duty;
    assign o_out.moving        = r_out_word.moving;
    assign o_out.move_done     = r_out_word.move_done;
    assign o_out.left_holes    = r_out_word.left_holes;
    assign o_out.right_holes   = r_out_word.right_holes;

    a_count_within_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_l <= r_goal) && (r_cnt_r <= r_goal))
        else $error("A wheel count has passed the move goal.");

    a_done_ends_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_out_word.move_done) |=> !r_active)
        else $error("The move is still active after its done word.");

    a_idle_word_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.moving && !r_out_word.move_done)
            |-> (r_out_word.left_duty == '0) && (r_out_word.right_duty == '0)
                && r_out_word.left_forward && r_out_word.right_forward)
        else $error("An idle word drives a wheel.");

endmodule
